// ===== design/rbki_pkg.sv =====
// Package for the rigid body kinematic integrator: widths, codes, state enum.
// No dependencies.
package rbki_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_BITS = 31;
  localparam int CMD_BITS = 3;
  localparam int REG_IDX_BITS = 2;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_FORCE = 3'd1;
  localparam logic [2:0] CMD_TORQUE = 3'd2;
  localparam logic [2:0] CMD_LOAD_POS = 3'd3;
  localparam logic [2:0] CMD_LOAD_VEL = 3'd4;

  localparam logic [1:0] REG_BODY_TYPE = 2'd0;
  localparam logic [1:0] REG_MASS = 2'd1;
  localparam logic [1:0] REG_INERTIA = 2'd2;

  localparam logic [1:0] BODY_STATIC = 2'd0;
  localparam logic [1:0] BODY_KINEMATIC = 2'd1;
  localparam logic [1:0] BODY_DYNAMIC = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_DT2, OP_VDT, OP_ADT2, OP_ADT, OP_COMMIT_AX, OP_DIV_START,
    OP_DIV_STEP, OP_DIV_DONE, OP_LOAD_POS, OP_LOAD_VEL, OP_ZERO_ACC, OP_ZERO_VEL
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DT2, ST_VDT, ST_ADT2, ST_ADT, ST_COMMIT, ST_DIV_START, ST_DIV_STEP,
    ST_DIV_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
    logic [1:0] axis;   // 0..2 linear axes, 3 angular
    logic capture;      // load output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;
endpackage

// ===== design/rbki_ctrl.sv =====
// Controller state machine for the integrator.
// Depends on rbki_pkg.
module rbki_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [rbki_pkg::CMD_BITS-1:0] cmd,
  input  logic [1:0] body_type,
  output logic out_valid,
  input  logic out_stall,
  output rbki_pkg::cmd_t ctl,
  input  rbki_pkg::stat_t stat
);
  rbki_pkg::state_t state, state_next;
  logic [rbki_pkg::CMD_BITS-1:0] op_cmd, op_cmd_next;
  logic [1:0] axis, axis_next;
  logic ovalid, ovalid_next;
  logic still;

  assign still = (body_type == rbki_pkg::BODY_STATIC) ||
                 (body_type == rbki_pkg::BODY_KINEMATIC);
  assign out_valid = ovalid;
  // output register frees when taken; accept when idle and output free or leaving
  assign in_stall = (state != rbki_pkg::ST_IDLE) || (ovalid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbki_pkg::ST_IDLE;
      op_cmd <= '0;
      axis <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      op_cmd <= op_cmd_next;
      axis <= axis_next;
      ovalid <= ovalid_next;
    end
  end

  always_comb begin
    state_next = state;
    op_cmd_next = op_cmd;
    axis_next = axis;
    ovalid_next = ovalid && out_stall;
    ctl = '{op: rbki_pkg::OP_NONE, axis: axis, capture: 1'b0};
    unique case (state)
      rbki_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          op_cmd_next = cmd;
          axis_next = 2'd0;
          unique case (cmd)
            rbki_pkg::CMD_TICK: state_next = rbki_pkg::ST_DT2;
            rbki_pkg::CMD_FORCE: begin
              if (still) begin
                ctl.op = rbki_pkg::OP_ZERO_ACC;
                state_next = rbki_pkg::ST_OUT;
              end else begin
                state_next = rbki_pkg::ST_DIV_START;
              end
            end
            rbki_pkg::CMD_TORQUE: begin
              axis_next = 2'd3;
              state_next = rbki_pkg::ST_DIV_START;
            end
            rbki_pkg::CMD_LOAD_POS: begin
              ctl.op = rbki_pkg::OP_LOAD_POS;
              state_next = rbki_pkg::ST_OUT;
            end
            rbki_pkg::CMD_LOAD_VEL: begin
              ctl.op = rbki_pkg::OP_LOAD_VEL;
              state_next = rbki_pkg::ST_OUT;
            end
            default: state_next = rbki_pkg::ST_OUT;
          endcase
        end
      end
      rbki_pkg::ST_DT2: begin
        ctl.op = rbki_pkg::OP_DT2;
        state_next = rbki_pkg::ST_VDT;
      end
      rbki_pkg::ST_VDT: begin
        ctl.op = rbki_pkg::OP_VDT;
        state_next = rbki_pkg::ST_ADT2;
      end
      rbki_pkg::ST_ADT2: begin
        ctl.op = rbki_pkg::OP_ADT2;
        state_next = rbki_pkg::ST_ADT;
      end
      rbki_pkg::ST_ADT: begin
        ctl.op = rbki_pkg::OP_ADT;
        state_next = rbki_pkg::ST_COMMIT;
      end
      rbki_pkg::ST_COMMIT: begin
        ctl.op = rbki_pkg::OP_COMMIT_AX;
        if (axis == 2'd3) begin
          state_next = rbki_pkg::ST_OUT;
        end else begin
          axis_next = axis + 2'd1;
          state_next = rbki_pkg::ST_VDT;
        end
      end
      rbki_pkg::ST_DIV_START: begin
        ctl.op = rbki_pkg::OP_DIV_START;
        state_next = rbki_pkg::ST_DIV_STEP;
      end
      rbki_pkg::ST_DIV_STEP: begin
        ctl.op = rbki_pkg::OP_DIV_STEP;
        if (stat.div_done) state_next = rbki_pkg::ST_DIV_DONE;
      end
      rbki_pkg::ST_DIV_DONE: begin
        ctl.op = rbki_pkg::OP_DIV_DONE;
        if (op_cmd == rbki_pkg::CMD_FORCE && axis != 2'd2) begin
          axis_next = axis + 2'd1;
          state_next = rbki_pkg::ST_DIV_START;
        end else begin
          state_next = rbki_pkg::ST_OUT;
        end
      end
      rbki_pkg::ST_OUT: begin
        if (op_cmd == rbki_pkg::CMD_TICK && body_type == rbki_pkg::BODY_STATIC)
          ctl.op = rbki_pkg::OP_ZERO_VEL;
        if (!ovalid_next) begin
          ctl.capture = 1'b1;
          ovalid_next = 1'b1;
          state_next = rbki_pkg::ST_IDLE;
        end
      end
      default: state_next = rbki_pkg::ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != rbki_pkg::ST_IDLE |-> in_stall) else $error("accept while busy");
  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> !(ovalid && out_stall)) else $error("overwrite of held result");
endmodule

// ===== design/rbki_datapath.sv =====
// Datapath: state registers, one shared multiplier, a restoring divider, output register.
// Depends on rbki_pkg.
module rbki_datapath #(
  parameter int WORD_BITS = rbki_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rbki_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_accept,
  input  logic signed [WORD_BITS-1:0] vec_x,
  input  logic signed [WORD_BITS-1:0] vec_y,
  input  logic signed [WORD_BITS-1:0] vec_z,
  input  logic signed [WORD_BITS-1:0] scalar,
  input  logic [rbki_pkg::CFG_BITS-1:0] mass,
  input  logic [rbki_pkg::CFG_BITS-1:0] rotational_inertia,
  input  rbki_pkg::cmd_t ctl,
  output rbki_pkg::stat_t stat,
  output logic signed [WORD_BITS-1:0] out_pos_x,
  output logic signed [WORD_BITS-1:0] out_pos_y,
  output logic signed [WORD_BITS-1:0] out_pos_z,
  output logic signed [WORD_BITS-1:0] out_angle,
  output logic signed [WORD_BITS-1:0] out_vel_x,
  output logic signed [WORD_BITS-1:0] out_vel_y,
  output logic signed [WORD_BITS-1:0] out_vel_z,
  output logic signed [WORD_BITS-1:0] out_angular_vel
);
  localparam int PW = 2 * WORD_BITS;
  localparam int AW = PW + 2;
  localparam int NW = WORD_BITS + FRAC_BITS;       // divider numerator magnitude
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [AW-1:0] WMAX = AW'((64'sd1 <<< (WORD_BITS - 1)) - 1);
  localparam logic signed [AW-1:0] WMIN = -WMAX - AW'(1);

  // index 0..2 linear axes, 3 angular
  logic signed [WORD_BITS-1:0] pos [4];
  logic signed [WORD_BITS-1:0] vel [4];
  logic signed [WORD_BITS-1:0] acc [4];
  logic signed [WORD_BITS-1:0] dt, dt2;
  logic signed [AW-1:0] pos_sum;

  logic signed [WORD_BITS-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh, prod_sh1;

  // divider
  logic [NW-1:0] quo;
  logic [NW:0] rem;
  logic [NW:0] rem_sh;
  logic [CW-1:0] cnt;
  logic neg, dzero, numzero;
  logic [rbki_pkg::CFG_BITS-1:0] dsr;
  logic signed [AW-1:0] qsig, qsat;

  function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [AW-1:0] v);
    if (v > WMAX) return WMAX[WORD_BITS-1:0];
    if (v < WMIN) return WMIN[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

  always_comb begin
    mul_a = dt;
    mul_b = dt;
    unique case (ctl.op)
      rbki_pkg::OP_VDT: begin mul_a = vel[ctl.axis]; mul_b = dt; end
      rbki_pkg::OP_ADT2: begin mul_a = acc[ctl.axis]; mul_b = dt2; end
      rbki_pkg::OP_ADT: begin mul_a = acc[ctl.axis]; mul_b = dt; end
      default: begin mul_a = dt; mul_b = dt; end
    endcase
  end

  always_ff @(posedge clk) prod <= PW'(mul_a) * PW'(mul_b);
  assign prod_sh = prod >>> FRAC_BITS;
  assign prod_sh1 = prod >>> (FRAC_BITS + 1);

  assign rem_sh = {rem[NW-1:0], quo[NW-1]};
  assign stat.div_done = (cnt == '0);
  assign qsig = neg ? -AW'($signed({1'b0, quo})) : AW'($signed({1'b0, quo}));
  assign qsat = dzero ? (numzero ? '0 : (neg ? WMIN : WMAX)) : qsig;

  // latch inputs on accept; scalar doubles as dt/torque
  logic [WORD_BITS-1:0] hold_vec [3];
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dt <= scalar;
      hold_vec[0] <= vec_x;
      hold_vec[1] <= vec_y;
      hold_vec[2] <= vec_z;
    end
  end

  logic signed [WORD_BITS-1:0] hv;
  logic [WORD_BITS-1:0] hmag;
  assign hv = (ctl.axis == 2'd3) ? dt : $signed(hold_vec[ctl.axis]);
  assign hmag = hv[WORD_BITS-1] ? WORD_BITS'(-hv) : WORD_BITS'(hv);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        pos[i] <= '0; vel[i] <= '0; acc[i] <= '0;
      end
    end else begin
      unique case (ctl.op)
        rbki_pkg::OP_DT2: ;
        rbki_pkg::OP_VDT: dt2 <= sat_w(AW'(prod_sh));
        rbki_pkg::OP_ADT2: pos_sum <= AW'(pos[ctl.axis]) + AW'(prod_sh);
        rbki_pkg::OP_ADT: pos_sum <= pos_sum + AW'(prod_sh1);
        rbki_pkg::OP_COMMIT_AX: begin
          pos[ctl.axis] <= sat_w(pos_sum);
          vel[ctl.axis] <= sat_w(AW'(vel[ctl.axis]) + AW'(prod_sh));
        end
        rbki_pkg::OP_DIV_START: begin
          quo <= {hmag, {FRAC_BITS{1'b0}}};
          rem <= '0;
          cnt <= CW'(NW);
          neg <= hv[WORD_BITS-1];
          numzero <= (hv == '0);
          dsr <= (ctl.axis == 2'd3) ? rotational_inertia : mass;
          dzero <= ((ctl.axis == 2'd3) ? rotational_inertia : mass) == '0;
        end
        rbki_pkg::OP_DIV_STEP: begin
          if (cnt != '0) begin
            cnt <= cnt - CW'(1);
            if (rem_sh >= (NW+1)'(dsr)) begin
              rem <= rem_sh - (NW+1)'(dsr);
              quo <= {quo[NW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[NW-2:0], 1'b0};
            end
          end
        end
        rbki_pkg::OP_DIV_DONE: acc[ctl.axis] <= sat_w(qsat);
        rbki_pkg::OP_LOAD_POS: begin
          pos[0] <= vec_x; pos[1] <= vec_y; pos[2] <= vec_z; pos[3] <= scalar;
        end
        rbki_pkg::OP_LOAD_VEL: begin
          vel[0] <= vec_x; vel[1] <= vec_y; vel[2] <= vec_z; vel[3] <= scalar;
        end
        rbki_pkg::OP_ZERO_ACC: begin
          acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
        end
        rbki_pkg::OP_ZERO_VEL: begin
          vel[0] <= '0; vel[1] <= '0; vel[2] <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register, loaded with the zero-velocity override folded in
  logic zv;
  assign zv = (ctl.op == rbki_pkg::OP_ZERO_VEL);
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      out_pos_x <= pos[0]; out_pos_y <= pos[1]; out_pos_z <= pos[2];
      out_angle <= pos[3];
      out_vel_x <= zv ? '0 : vel[0];
      out_vel_y <= zv ? '0 : vel[1];
      out_vel_z <= zv ? '0 : vel[2];
      out_angular_vel <= vel[3];
    end
  end
endmodule

// ===== design/rigid_body_kinematic_integrator.sv =====
// Top level of the rigid body kinematic integrator.
// Depends on rbki_pkg, rbki_ctrl, rbki_datapath.
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------
//  input   | in        | in_valid, in_stall, cmd, vec_x/y/z, scalar
//  output  | out       | out_valid, out_stall, out_pos_*, out_angle, out_vel_*, ...
//  config  | in        | cfg_we, cfg_index, cfg_data
//
// A tick squares dt once, then for each of the four axes forms three products
// through the single registered multiplier and commits them, then loads the
// output register. A force runs the restoring divider once per linear axis,
// one quotient bit a cycle; a torque runs it once for the angular axis; loads,
// a force on a static or kinematic body and undefined codes go straight to the
// output step.
// Reset clears state to zero and registers to dynamic, mass 1.0, inertia 1.0.
// The result waits in an output register; a new transfer is accepted once the
// block is idle and that register is free or being taken.
module rigid_body_kinematic_integrator #(
  parameter int WORD_BITS = rbki_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rbki_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rbki_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [rbki_pkg::CFG_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [rbki_pkg::CMD_BITS-1:0] cmd,
  input  logic signed [WORD_BITS-1:0] vec_x,
  input  logic signed [WORD_BITS-1:0] vec_y,
  input  logic signed [WORD_BITS-1:0] vec_z,
  input  logic signed [WORD_BITS-1:0] scalar,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [WORD_BITS-1:0] out_pos_x,
  output logic signed [WORD_BITS-1:0] out_pos_y,
  output logic signed [WORD_BITS-1:0] out_pos_z,
  output logic signed [WORD_BITS-1:0] out_angle,
  output logic signed [WORD_BITS-1:0] out_vel_x,
  output logic signed [WORD_BITS-1:0] out_vel_y,
  output logic signed [WORD_BITS-1:0] out_vel_z,
  output logic signed [WORD_BITS-1:0] out_angular_vel
);
  logic [1:0] body_type;
  logic [rbki_pkg::CFG_BITS-1:0] mass, rotational_inertia;
  rbki_pkg::cmd_t ctl;
  rbki_pkg::stat_t stat;
  logic in_accept;

  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      body_type <= rbki_pkg::BODY_DYNAMIC;
      mass <= rbki_pkg::CFG_BITS'(1 << FRAC_BITS);
      rotational_inertia <= rbki_pkg::CFG_BITS'(1 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbki_pkg::REG_BODY_TYPE: body_type <= cfg_data[1:0];
        rbki_pkg::REG_MASS: mass <= cfg_data;
        rbki_pkg::REG_INERTIA: rotational_inertia <= cfg_data;
        default: ;
      endcase
    end
  end

  rbki_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .cmd, .body_type,
    .out_valid, .out_stall, .ctl, .stat
  );

  rbki_datapath #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .in_accept, .vec_x, .vec_y, .vec_z, .scalar,
    .mass, .rotational_inertia, .ctl, .stat,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_angle,
    .out_vel_x, .out_vel_y, .out_vel_z, .out_angular_vel
  );
endmodule
